### rtl/bmpc_pkg.sv
// Package with the payload types, register codes and conversion helpers of the BMP pixel converter.
`timescale 1ns / 1ps
`default_nettype none
package bmpc_pkg;

  localparam int PaletteDepthDef = 256;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 8;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_PIXEL_FORMAT = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_RED_SHIFT    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_GREEN_SHIFT  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_BLUE_SHIFT   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_RED_MASK     = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_GREEN_MASK   = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_BLUE_MASK    = 3'd6;

  // Pixel formats.
  localparam logic [1:0] FMT_PAL4   = 2'd0;
  localparam logic [1:0] FMT_PAL8   = 2'd1;
  localparam logic [1:0] FMT_BITS16 = 2'd2;
  localparam logic [1:0] FMT_DIRECT = 2'd3;

  // Item actions.
  localparam logic ACT_WRITE   = 1'b0;
  localparam logic ACT_CONVERT = 1'b1;

  // Register reset values.
  localparam logic [1:0] RST_PIXEL_FORMAT = FMT_DIRECT;
  localparam logic [3:0] RST_RED_SHIFT    = 4'd10;
  localparam logic [3:0] RST_GREEN_SHIFT  = 4'd5;
  localparam logic [3:0] RST_BLUE_SHIFT   = 4'd0;
  localparam logic [7:0] RST_MASK         = 8'h1F;

  typedef struct packed {
    logic        action;
    logic [7:0]  entry_index;
    logic [23:0] entry_color;
    logic [23:0] raw_pixel;
    logic        odd_pixel;
    logic        last_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_out;
  } out_item_t;

  function automatic logic [3:0] popcount8(input logic [7:0] m);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'd0, m[i]};
    end
    return n;
  endfunction

  // One channel of a 16-bit bitfield pixel, left-aligned by the mask width.
  function automatic logic [7:0] channel16(input logic [15:0] word,
                                           input logic [3:0]  shift,
                                           input logic [7:0]  mask);
    logic [15:0] shifted;
    logic [7:0]  v;
    logic [3:0]  bits;
    logic [3:0]  lsh;
    shifted = word >> shift;
    v       = shifted[7:0] & mask;
    bits    = popcount8(mask);
    lsh     = 4'd8 - bits;
    if (bits < 4'd8) begin
      v = v << lsh[2:0];
      if (bits == 4'd0) begin
        v = 8'd0;
      end
    end
    return v;
  endfunction

endpackage
`default_nettype wire

### rtl/bmp_pixel_to_rgb888_core.sv
// Top level of the BMP pixel converter: palette store, config registers and a two-stage pipeline.
//
// The block turns raw BMP pixels into 8-bit red, green and blue. Items arrive on a
// valid/ready input channel; an item with action ACT_WRITE loads one palette entry
// and gives no result, an item with action ACT_CONVERT gives exactly one result on
// the valid/ready output channel. The pixel format and the bitfield shifts and
// masks are set through a plain write port; the user writes them only while the block is
// idle, the block itself does not enforce it. From input transfer to result valid an item
// passes two register stages: the first holds the registered palette read, the second is
// the output register. Throughput is one item per cycle while the receiver does not stall;
// the single-port palette memory is written or read once per transfer, which sets that figure.
// When the receiver stalls, the output register and the first stage fill up and
// input ready drops only once both hold a result. Reset clears the pipeline
// valids and sets the registers to direct 24-bit mode with 5-5-5 bitfields; the
// palette contents stay undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module bmp_pixel_to_rgb888_core
  import bmpc_pkg::*;
#(
  parameter int PALETTE_DEPTH = PaletteDepthDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire in_item_t            in_data_i,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      out_item_t           out_data_o
);

  localparam int AddrW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam logic [8:0] DepthVal = 9'(PALETTE_DEPTH);

  // Configuration registers.
  logic [1:0] fmt_q;
  logic [3:0] rsh_q, gsh_q, bsh_q;
  logic [7:0] rmask_q, gmask_q, bmask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q   <= RST_PIXEL_FORMAT;
      rsh_q   <= RST_RED_SHIFT;
      gsh_q   <= RST_GREEN_SHIFT;
      bsh_q   <= RST_BLUE_SHIFT;
      rmask_q <= RST_MASK;
      gmask_q <= RST_MASK;
      bmask_q <= RST_MASK;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PIXEL_FORMAT: fmt_q   <= cfg_wdata_i[1:0];
        CFG_RED_SHIFT:    rsh_q   <= cfg_wdata_i[3:0];
        CFG_GREEN_SHIFT:  gsh_q   <= cfg_wdata_i[3:0];
        CFG_BLUE_SHIFT:   bsh_q   <= cfg_wdata_i[3:0];
        CFG_RED_MASK:     rmask_q <= cfg_wdata_i;
        CFG_GREEN_MASK:   gmask_q <= cfg_wdata_i;
        CFG_BLUE_MASK:    bmask_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Pipeline control.
  logic in_xfer;
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic s1_move;

  assign s1_move    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_move;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Palette index and its range check.
  logic [7:0]       pal_idx;
  logic             pal_in_range;
  logic [AddrW-1:0] pal_addr;
  logic [AddrW-1:0] wr_addr;
  logic             wr_in_range;
  logic             is_pal;

  always_comb begin
    pal_idx = in_data_i.raw_pixel[7:0];
    if (fmt_q == FMT_PAL4) begin
      pal_idx = in_data_i.odd_pixel ? {4'd0, in_data_i.raw_pixel[3:0]}
                                    : {4'd0, in_data_i.raw_pixel[7:4]};
    end
  end

  assign is_pal       = (fmt_q == FMT_PAL4) || (fmt_q == FMT_PAL8);
  assign pal_in_range = {1'b0, pal_idx} < DepthVal;
  assign pal_addr     = pal_idx[AddrW-1:0];
  assign wr_in_range  = {1'b0, in_data_i.entry_index} < DepthVal;
  assign wr_addr      = in_data_i.entry_index[AddrW-1:0];

  // Palette memory with registered read.
  logic [23:0] palette_mem [PALETTE_DEPTH];
  logic [23:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      if (in_data_i.action == ACT_WRITE) begin
        if (wr_in_range) begin
          palette_mem[wr_addr] <= in_data_i.entry_color;
        end
      end else if (is_pal && pal_in_range) begin
        rd_q <= palette_mem[pal_addr];
      end
    end
  end

  // Non-palette conversion done before the first register.
  logic [15:0] word;
  logic [23:0] direct_rgb;

  always_comb begin
    word = in_data_i.raw_pixel[15:0];
    if (fmt_q == FMT_BITS16) begin
      direct_rgb = {channel16(word, rsh_q, rmask_q),
                    channel16(word, gsh_q, gmask_q),
                    channel16(word, bsh_q, bmask_q)};
    end else if (fmt_q == FMT_DIRECT) begin
      direct_rgb = in_data_i.raw_pixel;
    end else begin
      // Palette read beyond the store gives black.
      direct_rgb = 24'd0;
    end
  end

  // First stage payload.
  logic        s1_use_pal_q;
  logic [23:0] s1_rgb_q;
  logic        s1_last_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_use_pal_q <= is_pal && pal_in_range;
      s1_rgb_q     <= direct_rgb;
      s1_last_q    <= in_data_i.last_in;
    end
  end

  logic [23:0] s1_color;
  assign s1_color = s1_use_pal_q ? rd_q : s1_rgb_q;

  // Output register.
  out_item_t out_q;

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_q.red      <= s1_color[23:16];
      out_q.green    <= s1_color[15:8];
      out_q.blue     <= s1_color[7:0];
      out_q.last_out <= s1_last_q;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    if (in_xfer && (in_data_i.action == ACT_CONVERT)) begin
      s1_valid_d = 1'b1;
    end
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (s1_move) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire
